/* hw/rtl/dds_tw_pkg.sv */
// Package for the DDS tuning word encoder: request and result payload types
// and the fixed constants of the command word format. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dds_tw_pkg;

	typedef struct packed {
		logic               mode;
		logic               reg_select;
		logic [31:0]        freq_hz;
		logic signed [31:0] phase_sixtyfourths;
	} req_t;

	typedef struct packed {
		logic [15:0] command_word;
		logic        last;
	} res_t;

	localparam logic [31:0] MCLK_RESET   = 32'd75000000;
	localparam logic [27:0] TW_SAT       = 28'h0FFFFFFF;
	localparam logic [15:0] FREQ_ADDR0   = 16'h4000;
	localparam logic [15:0] FREQ_ADDR1   = 16'h8000;
	localparam logic [15:0] PHASE_ADDR0  = 16'hC000;
	localparam logic [15:0] PHASE_ADDR1  = 16'hE000;
	// Smallest multiple of a full turn (23040) that is at least 2^31.
	localparam logic [32:0] PHASE_OFFSET = 33'd2147489280;
	localparam logic [5:0]  MOD_45       = 6'd45;
	localparam logic [17:0] PH_ROUND     = 18'd22;
	// ceil(2^24 / 45): exact floor division by 45 for values below 2^18.
	localparam logic [18:0] RECIP_45     = 19'd372828;
	localparam int          RECIP_SHIFT  = 24;

	// Division pipeline: 28 quotient bits, two per stage.
	localparam int DIV_STAGES = 14;
	// Phase reduction: 24 bits of (offset phase >> 9), two per stage.
	localparam int PH_STAGES  = 12;

endpackage

`default_nettype wire

/* hw/rtl/dds_tuning_word_encoder_core.sv */
// DDS tuning word encoder: pipelined tuning word divider, phase reduction
// and command word output. Depends on dds_tw_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The first result word passes the capture stage, the division stages, the multiply
// stage and the output register; the second word of a frequency request follows in the next cycle.
// Throughput: a phase request can be taken every cycle, a frequency request
// holds busy high for one cycle after it, since the single output port
// carries one word per cycle. The receiver cannot stall the block.
// Reset clears all valid bits and loads the master clock with 75 MHz.
module dds_tuning_word_encoder_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire dds_tw_pkg::req_t  request,
	output logic                   result_valid,
	output dds_tw_pkg::res_t       result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [31:0]       cfg_data
);

	localparam int NS = dds_tw_pkg::DIV_STAGES;
	localparam int NP = dds_tw_pkg::PH_STAGES;

	// Master clock register. A zero write is dropped, so the divisor is never zero.
	logic [31:0] mclk_q;
	logic        busy_q;
	logic        accept;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mclk_q <= dds_tw_pkg::MCLK_RESET;
		end else if (cfg_valid && cfg_ready && cfg_data != 32'd0) begin
			mclk_q <= cfg_data;
		end
	end

	// A frequency request produces two words, so busy holds off the next request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept && !request.mode;
		end
	end

	// One restoring division step: shift in one numerator bit, subtract if it fits.
	// The remainder stays below the divisor, so the difference fits 32 bits.
	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
			input logic [31:0] dvs);
		logic [32:0] t;
		logic [32:0] d;
		t = {rem, nbit};
		d = t - {1'b0, dvs};
		if (t >= {1'b0, dvs}) begin
			div_step = {1'b1, d[31:0]};
		end else begin
			div_step = {1'b0, t[31:0]};
		end
	endfunction

	// One step of the remainder modulo 45.
	function automatic logic [5:0] mod45_step(input logic [5:0] rem, input logic nbit);
		logic [6:0] t;
		logic [6:0] d;
		t = {rem, nbit};
		d = t - {1'b0, dds_tw_pkg::MOD_45};
		if (t >= {1'b0, dds_tw_pkg::MOD_45}) begin
			mod45_step = d[5:0];
		end else begin
			mod45_step = t[5:0];
		end
	endfunction

	// Pipeline registers, indexed by stage: entry 0 is the request capture,
	// entries 1 to NS each retire two quotient bits.
	logic        vld_s   [0:NS];
	logic        mode_s  [0:NS];
	logic        sel_s   [0:NS];
	logic        sat_s   [0:NS];
	logic [31:0] rem_s   [0:NS];
	logic [27:0] nb_s    [0:NS];
	logic [27:0] q_s     [0:NS];
	logic [5:0]  prem_s  [0:NS];
	logic [23:0] pbits_s [0:NS];
	logic [8:0]  plow_s  [0:NS];

	// Capture stage. The numerator is freq * 2^28 + floor(mclk / 2); its upper
	// 33 bits are freq plus the top three bits of the half clock, and its low
	// 28 bits are the rest of the half clock. A top part at or above the divisor
	// means the quotient does not fit 28 bits and saturates.
	logic [30:0] half_clk;
	logic [32:0] num_hi;
	logic [32:0] ph_off;

	assign half_clk = mclk_q[31:1];
	assign num_hi   = {1'b0, request.freq_hz} + {30'd0, half_clk[30:28]};
	// Adding a whole number of turns makes the phase nonnegative without
	// changing its residue modulo a full turn.
	assign ph_off   = {request.phase_sixtyfourths[31], request.phase_sixtyfourths}
			+ dds_tw_pkg::PHASE_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		mode_s[0]  <= request.mode;
		sel_s[0]   <= request.reg_select;
		sat_s[0]   <= num_hi >= {1'b0, mclk_q};
		rem_s[0]   <= num_hi[31:0];
		nb_s[0]    <= half_clk[27:0];
		q_s[0]     <= 28'd0;
		prem_s[0]  <= 6'd0;
		pbits_s[0] <= ph_off[32:9];
		plow_s[0]  <= ph_off[8:0];
	end

	for (genvar k = 1; k <= NS; k++) begin : g_stage
		logic [32:0] st_a;
		logic [32:0] st_b;
		logic [5:0]  pm_a;
		logic [5:0]  pm_b;

		assign st_a = div_step(rem_s[k-1], nb_s[k-1][27], mclk_q);
		assign st_b = div_step(st_a[31:0], nb_s[k-1][26], mclk_q);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			mode_s[k] <= mode_s[k-1];
			sel_s[k]  <= sel_s[k-1];
			sat_s[k]  <= sat_s[k-1];
			rem_s[k]  <= st_b[31:0];
			nb_s[k]   <= {nb_s[k-1][25:0], 2'b00};
			q_s[k]    <= {q_s[k-1][25:0], st_a[32], st_b[32]};
			plow_s[k] <= plow_s[k-1];
		end

		if (k <= NP) begin : g_phase
			assign pm_a = mod45_step(prem_s[k-1], pbits_s[k-1][23]);
			assign pm_b = mod45_step(pm_a, pbits_s[k-1][22]);
			always_ff @(posedge clk) begin
				prem_s[k]  <= pm_b;
				pbits_s[k] <= {pbits_s[k-1][21:0], 2'b00};
			end
		end else begin : g_phase_hold
			assign pm_a = prem_s[k-1];
			assign pm_b = pm_a;
			always_ff @(posedge clk) begin
				prem_s[k]  <= pm_b;
				pbits_s[k] <= pbits_s[k-1];
			end
		end
	end

	// Multiply stage. With p = r45 * 512 + low9 the phase word is
	// (p * 8 + 22) / 45, done as a multiply by the reciprocal of 45.
	logic [17:0] ph_x;
	logic        vld_s16;
	logic        mode_s16;
	logic        sel_s16;
	logic [27:0] tw_s16;
	logic [36:0] prod_s16;

	assign ph_x = {prem_s[NS], 12'd0} + {6'd0, plow_s[NS], 3'b000} + dds_tw_pkg::PH_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
		end else begin
			vld_s16 <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		mode_s16 <= mode_s[NS];
		sel_s16  <= sel_s[NS];
		tw_s16   <= sat_s[NS] ? dds_tw_pkg::TW_SAT : q_s[NS];
		prod_s16 <= {19'd0, ph_x} * {18'd0, dds_tw_pkg::RECIP_45};
	end

	// Output stage. The first word leaves at once; the high tuning word of a
	// frequency request is held for the next cycle. busy spacing guarantees
	// no new item reaches this stage while that word is pending.
	logic [15:0] freq_addr;
	logic [15:0] phase_addr;
	logic [11:0] ph_word;
	logic        pend_q;
	logic [15:0] pend_word_q;
	logic        result_valid_q;
	dds_tw_pkg::res_t result_q;

	assign freq_addr  = sel_s16 ? dds_tw_pkg::FREQ_ADDR1 : dds_tw_pkg::FREQ_ADDR0;
	assign phase_addr = sel_s16 ? dds_tw_pkg::PHASE_ADDR1 : dds_tw_pkg::PHASE_ADDR0;
	assign ph_word    = prod_s16[dds_tw_pkg::RECIP_SHIFT +: 12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			pend_q         <= vld_s16 && !mode_s16;
			result_valid_q <= vld_s16 || pend_q;
		end
	end

	always_ff @(posedge clk) begin
		pend_word_q <= freq_addr | {2'b00, tw_s16[27:14]};
		if (vld_s16) begin
			if (mode_s16) begin
				result_q.command_word <= phase_addr | {4'd0, ph_word};
				result_q.last         <= 1'b1;
			end else begin
				result_q.command_word <= freq_addr | {2'b00, tw_s16[13:0]};
				result_q.last         <= 1'b0;
			end
		end else begin
			result_q.command_word <= pend_word_q;
			result_q.last         <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The master clock can never become zero.
	a_mclk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mclk_q != 32'd0) else $error("master clock register is zero");

	// A frequency request blocks exactly one following cycle.
	a_busy_after_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !request.mode) |=> busy) else $error("busy missing");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy held too long");

	// A first tuning word is always followed by the closing word.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=> (result_valid && result.last))
		else $error("second tuning word missing");

	// A new item never reaches the output while a word is pending.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && vld_s16)) else $error("output collision");

endmodule

`default_nettype wire
